FILE: rtl/core/ppd_pkg.sv
package ppd_pkg;

  // field widths fixed by the interface
  localparam int TS_BITS    = 32;
  localparam int CW_BITS    = 16;  // width_min / width_max
  localparam int THR_BITS   = 15;
  localparam int POS_BITS   = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // pulse widths saturate at 2^24 ticks
  localparam int CLAMP_LOG2 = 24;
  localparam int PW_BITS    = CLAMP_LOG2 + 1;
  localparam logic [PW_BITS-1:0] PW_CLAMP = PW_BITS'(1) << CLAMP_LOG2;

  // 2*width - max - min, signed, and its magnitude
  localparam int NUM_BITS = PW_BITS + 2;
  localparam int MAG_BITS = NUM_BITS - 1;

  localparam logic signed [POS_BITS-1:0] POS_MAX = 16'sh7fff;
  localparam logic signed [POS_BITS-1:0] POS_MIN = 16'sh8000;
  localparam logic [POS_BITS:0] QMAG_POS_SAT = 17'd32767;
  localparam logic [POS_BITS:0] QMAG_NEG_SAT = 17'd32768;

  localparam logic                  RST_ACTIVE_LEVEL = 1'b1;
  localparam logic [CW_BITS-1:0]    RST_WIDTH_MIN    = 16'd1000;
  localparam logic [CW_BITS-1:0]    RST_WIDTH_MAX    = 16'd2000;
  localparam logic [THR_BITS-1:0]   RST_THRESHOLD    = 15'd246;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_WIDTH_MIN    = 2'd1,
    CFG_WIDTH_MAX    = 2'd2,
    CFG_THRESHOLD    = 2'd3
  } cfg_idx_t;

  // doubled quotient from the serial divider, ovf set once it passed 16 bits
  typedef struct packed {
    logic                ovf;
    logic [POS_BITS-1:0] quo;
  } div_res_t;

endpackage

FILE: rtl/core/pwm_pulse_position_decoder.sv
// channel  | ports                                   | dir
// in       | in_valid, in_stall, in_edge_level,      | edge events in
//          | in_timestamp                            |
// out      | out_valid, out_stall, out_position      | positions out
// cfg      | cfg_we, cfg_index, cfg_data             | register writes
//
// an edge to the active level, or any edge while the range is empty, leaves
// the block idle; a measuring edge passes ST_NUM, ST_DIV and ST_CMP, with
// ST_DIV held by the bit-serial divider that walks MAG_BITS + FRAC_BITS + 1
// dividend bits one per cycle
// rst_n is synchronous; control and config registers return to reset values
// in_stall is high while a beat is in work; a waiting result sits in the
// output register, so a new beat is taken while out_stall holds it, but a
// new position to report waits in the compare step until that register frees
module pwm_pulse_position_decoder
  import ppd_pkg::*;
#(
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_edge_level,
  input  logic [TS_BITS-1:0]         in_timestamp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [POS_BITS-1:0] out_position,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int DVD_BITS = MAG_BITS + FRAC_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NUM,
    ST_DIV,
    ST_CMP
  } state_t;

  state_t                     state_r;
  logic                       cfg_active_level_r;
  logic [CW_BITS-1:0]         cfg_width_min_r;
  logic [CW_BITS-1:0]         cfg_width_max_r;
  logic [THR_BITS-1:0]        cfg_threshold_r;
  logic [CW_BITS:0]           range_sum_r;
  logic                       neg_r;
  logic signed [POS_BITS-1:0] pos_r;
  logic signed [POS_BITS-1:0] last_reported_r;
  logic                       out_valid_r;
  logic signed [POS_BITS-1:0] out_position_r;

  logic                       accept;
  logic                       is_start;
  logic                       range_ok;
  logic                       capture;
  logic                       measure;
  logic [PW_BITS-1:0]         width;
  logic [NUM_BITS-1:0]        num;
  logic                       num_neg;
  logic [MAG_BITS-1:0]        mag;
  logic                       div_load;
  logic [DVD_BITS-1:0]        dividend;
  logic [CW_BITS-1:0]         den;
  logic                       div_done;
  div_res_t                   div_res;
  logic [POS_BITS:0]          q_round;
  logic signed [POS_BITS-1:0] pos_nxt;
  logic signed [POS_BITS:0]   diff;
  logic signed [POS_BITS:0]   thr_ext;
  logic                       report;
  logic                       out_free;
  logic                       out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_start = (in_edge_level == cfg_active_level_r);
  assign range_ok = (cfg_width_max_r > cfg_width_min_r);
  assign capture  = accept && is_start;
  assign measure  = accept && !is_start && range_ok;

  ppd_pulse_timer #(
    .TICK_BITS(TICK_BITS)
  ) u_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .capture  (capture),
    .measure  (measure),
    .timestamp(in_timestamp),
    .width_o  (width)
  );

  always_comb begin
    num      = {1'b0, width, 1'b0} - NUM_BITS'(range_sum_r);
    num_neg  = num[NUM_BITS-1];
    mag      = num_neg ? MAG_BITS'(-num) : MAG_BITS'(num);
    dividend = {mag, (FRAC_BITS + 1)'(0)};
    den      = cfg_width_max_r - cfg_width_min_r;
    div_load = (state_r == ST_NUM);
  end

  ppd_serial_div #(
    .DVD_BITS(DVD_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (div_load),
    .dividend(dividend),
    .divisor (den),
    .done    (div_done),
    .res     (div_res)
  );

  // divider gives twice the quotient; halve it rounding half away from zero
  always_comb begin
    q_round = (POS_BITS + 1)'(({1'b0, div_res.quo} + (POS_BITS + 1)'(1)) >> 1);
    if (neg_r) begin
      if (div_res.ovf || q_round >= QMAG_NEG_SAT) begin
        pos_nxt = POS_MIN;
      end else begin
        pos_nxt = -$signed(q_round[POS_BITS-1:0]);
      end
    end else begin
      if (div_res.ovf || q_round >= QMAG_POS_SAT) begin
        pos_nxt = POS_MAX;
      end else begin
        pos_nxt = $signed(q_round[POS_BITS-1:0]);
      end
    end
  end

  always_comb begin
    diff     = (POS_BITS + 1)'(pos_r) - (POS_BITS + 1)'(last_reported_r);
    thr_ext  = $signed({2'b00, cfg_threshold_r});
    report   = (diff > thr_ext) || (diff < -thr_ext);
    out_free = !out_valid_r || !out_stall;
    out_load = (state_r == ST_CMP) && report && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_level_r <= RST_ACTIVE_LEVEL;
      cfg_width_min_r    <= RST_WIDTH_MIN;
      cfg_width_max_r    <= RST_WIDTH_MAX;
      cfg_threshold_r    <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_LEVEL: cfg_active_level_r <= cfg_data[0];
        CFG_WIDTH_MIN:    cfg_width_min_r    <= cfg_data[CW_BITS-1:0];
        CFG_WIDTH_MAX:    cfg_width_max_r    <= cfg_data[CW_BITS-1:0];
        CFG_THRESHOLD:    cfg_threshold_r    <= cfg_data[THR_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    range_sum_r <= {1'b0, cfg_width_max_r} + {1'b0, cfg_width_min_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      last_reported_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (measure) begin
            state_r <= ST_NUM;
          end
        end
        ST_NUM: begin
          neg_r   <= num_neg;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            pos_r   <= pos_nxt;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (!report) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_position_r  <= pos_r;
            last_reported_r <= pos_r;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;

`ifndef SYNTHESIS
  a_out_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_position_r == last_reported_r)
    else $error("pending beat differs from last reported position");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside of division");
  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cfg_width_max_r <= cfg_width_min_r) |=> state_r == ST_IDLE)
    else $error("empty range started a measurement");
`endif

endmodule

FILE: rtl/core/ppd_pulse_timer.sv
module ppd_pulse_timer
  import ppd_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               capture,
  input  logic               measure,
  input  logic [TS_BITS-1:0] timestamp,
  output logic [PW_BITS-1:0] width_o
);

  localparam int EXT_BITS = (TICK_BITS > PW_BITS) ? TICK_BITS : PW_BITS;

  logic [TICK_BITS-1:0] ts_tick;
  logic [TICK_BITS-1:0] pulse_start_r;
  logic [TICK_BITS-1:0] elapsed;
  logic [EXT_BITS-1:0]  elapsed_ext;
  logic                 sat;
  logic [PW_BITS-1:0]   width_r;
  logic [PW_BITS-1:0]   width_nxt;

  always_comb begin
    ts_tick     = TICK_BITS'(timestamp);
    // wraps modulo the tick counter width
    elapsed     = ts_tick - pulse_start_r;
    elapsed_ext = EXT_BITS'(elapsed);
    sat         = |elapsed_ext[EXT_BITS-1:CLAMP_LOG2];
    width_nxt   = sat ? PW_CLAMP : elapsed_ext[PW_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_start_r <= '0;
    end else if (capture) begin
      pulse_start_r <= ts_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (measure) begin
      width_r <= width_nxt;
    end
  end

  assign width_o = width_r;

endmodule

FILE: rtl/core/ppd_serial_div.sv
module ppd_serial_div
  import ppd_pkg::*;
#(
  parameter int DVD_BITS = 41
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [CW_BITS-1:0]  divisor,
  output logic                done,
  output div_res_t            res
);

  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0] dvd_r;
  logic [CW_BITS-1:0]  den_r;
  logic [CW_BITS-1:0]  rem_r;
  logic [CW_BITS-1:0]  rem_nxt;
  logic [POS_BITS-1:0] quo_r;
  logic                ovf_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [CW_BITS:0]    trial;
  logic                fits;

  // one dividend bit per cycle, restoring
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_BITS-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? CW_BITS'(trial - {1'b0, den_r}) : trial[CW_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DVD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[POS_BITS-2:0], fits};
      // any bit pushed out of the quotient means saturation
      ovf_r <= ovf_r | quo_r[POS_BITS-1];
    end
  end

  assign done    = done_r;
  assign res.ovf = ovf_r;
  assign res.quo = quo_r;

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r)
    else $error("divider reloaded while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still stepping");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with empty count");
`endif

endmodule

FILE: tb/ppd_checker.sv
module ppd_checker
  import ppd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_edge_level,
  input  logic [TS_BITS-1:0]         in_timestamp,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [POS_BITS-1:0] out_position,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  output logic [31:0]                fail_count,
  output logic [31:0]                pending,
  output logic [31:0]                positions_seen
);

  // shadow copy of the register file
  logic                       act_level;
  logic [CW_BITS-1:0]         wmin;
  logic [CW_BITS-1:0]         wmax;
  logic [THR_BITS-1:0]        thresh;

  logic [TS_BITS-1:0]         pulse_start;
  logic signed [POS_BITS-1:0] last_pos;

  logic signed [POS_BITS-1:0] expected_positions[$];
  int                         errors;
  int                         seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  // pulse width in ticks to saturated Q2.14 position, rounded half away from zero
  function automatic logic signed [POS_BITS-1:0] pos_from_width(input logic [TS_BITS-1:0] w_raw);
    longint w;
    longint num;
    longint den;
    longint mag;
    longint q;
    logic   neg;
    w = (w_raw > 32'h0100_0000) ? 64'sh100_0000 : longint'({32'b0, w_raw});
    num = 2 * w - longint'({48'b0, wmax}) - longint'({48'b0, wmin});
    den = longint'({48'b0, wmax}) - longint'({48'b0, wmin});
    neg = (num < 0);
    mag = (neg ? -num : num) * 16384;
    q = (2 * mag + den) / (2 * den);
    if (neg)
      return (q >= 32768) ? POS_MIN : POS_BITS'(-q);
    return (q >= 32767) ? POS_MAX : POS_BITS'(q);
  endfunction

  task automatic decode_edge(input logic level, input logic [TS_BITS-1:0] ts);
    logic [TS_BITS-1:0]         width;
    logic signed [POS_BITS-1:0] pos;
    int                         delta;
    if (level == act_level) begin
      pulse_start = ts;
    end else if (wmax > wmin) begin
      width = ts - pulse_start;
      pos = pos_from_width(width);
      delta = int'(pos) - int'(last_pos);
      if (delta < 0) delta = -delta;
      if (delta > int'({17'b0, thresh})) begin
        last_pos = pos;
        expected_positions.push_back(pos);
      end
    end
  endtask

  always @(posedge clk) begin
    logic signed [POS_BITS-1:0] want;
    if (!rst_n) begin
      act_level   = RST_ACTIVE_LEVEL;
      wmin        = RST_WIDTH_MIN;
      wmax        = RST_WIDTH_MAX;
      thresh      = RST_THRESHOLD;
      pulse_start = '0;
      last_pos    = '0;
      expected_positions.delete();
      errors      = 0;
      seen        = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("position %0d with none pending", out_position));
        end else begin
          want = expected_positions.pop_front();
          if (out_position !== want)
            report_mismatch($sformatf("position got %0d want %0d", out_position, want));
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ACTIVE_LEVEL: act_level = cfg_data[0];
          CFG_WIDTH_MIN:    wmin = cfg_data[CW_BITS-1:0];
          CFG_WIDTH_MAX:    wmax = cfg_data[CW_BITS-1:0];
          CFG_THRESHOLD:    thresh = cfg_data[THR_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        decode_edge(in_edge_level, in_timestamp);
    end
    fail_count     = errors;
    pending        = expected_positions.size();
    positions_seen = seen;
  end

endmodule

FILE: tb/tb_pwm_pulse_position_decoder.sv
module tb_pwm_pulse_position_decoder;
  import ppd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_edge_level = 1'b0;
  logic [TS_BITS-1:0]         in_timestamp = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [POS_BITS-1:0] out_position;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] positions_seen;

  logic hold_req = 1'b0;
  int   idle_cycles = 0;
  int   beats_sent = 0;
  int   burst_left = 0;
  int   settings_used = 1;
  int   stall_tick = 0;
  int   stall_mode = 0;

  // stimulus-side view of the current setting
  logic cur_act = RST_ACTIVE_LEVEL;
  int   cur_min = RST_WIDTH_MIN;
  int   cur_max = RST_WIDTH_MAX;

  always #6 clk = ~clk;

  pwm_pulse_position_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_edge_level (in_edge_level),
    .in_timestamp  (in_timestamp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_position  (out_position),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ppd_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_edge_level  (in_edge_level),
    .in_timestamp   (in_timestamp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position   (out_position),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .positions_seen (positions_seen)
  );

  wire beat_moved = (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we;

  always @(posedge clk) begin
    if (!rst_n || beat_moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
        stall_tick = (stall_tick + 1) % 256;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((stall_tick % 7) < 3);
        endcase
      end
    end
  end

  // one edge beat; called and returns at a falling edge
  task automatic send_edge(input logic lvl, input logic [TS_BITS-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_edge_level <= lvl;
    in_timestamp  <= ts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  // wait for every position, then for a measurement that may still be in work
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic act, input int wlo, input int whi, input int thr);
    drain();
    write_reg(CFG_ACTIVE_LEVEL, {15'($urandom), act});
    write_reg(CFG_WIDTH_MIN, 16'(wlo));
    write_reg(CFG_WIDTH_MAX, 16'(whi));
    // top bit lies outside the threshold register and is dropped
    write_reg(CFG_THRESHOLD, {1'($urandom), 15'(thr)});
    cur_act = act;
    cur_min = wlo;
    cur_max = whi;
    settings_used++;
  endtask

  function automatic logic [TS_BITS-1:0] pick_width();
    int span;
    int w;
    int r;
    span = (cur_max > cur_min) ? cur_max - cur_min : 1000;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      w = cur_min + int'($urandom_range(0, span + span / 2)) - span / 4;
      if (w < 0) w = 0;
      return TS_BITS'(w);
    end
    if (r < 17) return TS_BITS'($urandom_range(0, 140000));
    if (r < 19) return TS_BITS'($urandom_range(32'h00FF_FF00, 32'h0100_012C));
    return $urandom;
  endfunction

  task automatic run_random(input int n);
    int                 sent0;
    int                 kind;
    logic [TS_BITS-1:0] base;
    sent0 = beats_sent;
    while (beats_sent - sent0 < n) begin
      kind = $urandom_range(0, 9);
      base = $urandom;
      if (kind <= 6) begin
        send_edge(cur_act, base);
        send_edge(!cur_act, base + pick_width());
        if ($urandom_range(0, 4) == 0) send_edge(!cur_act, base + pick_width());
      end else if (kind == 7) begin
        send_edge(cur_act, $urandom);
        send_edge(cur_act, base);
        send_edge(!cur_act, base + pick_width());
      end else if (kind == 8) begin
        send_edge(1'($urandom), $urandom);
      end else begin
        send_edge(!cur_act, $urandom);
      end
    end
  endtask

  initial begin
    int wlo;
    int thr;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: active high, 1000..2000 ticks, threshold 246
    send_edge(1'b0, 32'd2000);                       // measure before any start
    send_edge(1'b1, 32'hFFFF_FF00);
    send_edge(1'b0, 32'hFFFF_FF00 + 32'd1500);       // timestamp wraps mid pulse
    send_edge(1'b1, 32'd100);
    send_edge(1'b0, 32'd1100);
    send_edge(1'b0, 32'd3100);                       // measure again, saturates high
    send_edge(1'b1, 32'd5);
    send_edge(1'b1, 32'd10);                         // second start wins
    send_edge(1'b0, 32'd1009);
    send_edge(1'b1, 32'd0);
    send_edge(1'b0, 32'h0100_0000);                  // width at the clamp
    send_edge(1'b0, 32'hFFFF_FFFF);                  // far beyond the clamp
    send_edge(1'b1, 32'h1234_5678);
    send_edge(1'b0, 32'h1234_5678);                  // zero width, saturates low
    send_edge(1'b1, 32'h8000_0000);
    send_edge(1'b0, 32'h8000_0000 + 32'd1500);
    send_edge(1'b0, 32'h8000_0000 + 32'd1510);       // change just beyond the threshold
    send_edge(1'b0, 32'h8000_0000 + 32'd1516);
    send_edge(1'b1, 32'hFFFF_FFFF);
    send_edge(1'b0, 32'd1499);

    configure(1'b0, 0, 65535, 0);
    run_random(120);
    configure(1'b1, 65535, 0, 100);                  // empty range
    run_random(60);
    configure(1'b1, 5000, 5000, 10);                 // min equal to max
    run_random(40);
    configure(1'b0, 100, 101, 32767);                // one-tick range
    run_random(100);

    // long output hold-off so the block backs up into its input
    configure(1'b1, 1000, 2000, 50);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    run_random(80);

    for (int p = 0; p < 8; p++) begin
      wlo = $urandom_range(0, 50000);
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 600);
      configure(1'($urandom), wlo, wlo + $urandom_range(1, 15000), thr);
      run_random(110);
    end
    drain();

    $display("run covered %0d edge beats and %0d positions over %0d register settings",
             beats_sent, positions_seen, settings_used);
    $display("settings spanned empty and one-tick ranges, both active levels and zero to full thresholds");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
